FILE: hw/rtl/ups_pkg.sv
// ----------------------------------------------------------------------------
// ups_pkg
// shared types, constants and character tables of the url prefix scanner
// ----------------------------------------------------------------------------
package ups_pkg;

  localparam int unsigned PosWidth  = 32;
  localparam int unsigned LenWidth  = 32;
  localparam int unsigned NodeWidth = 7;
  localparam int unsigned NodeCount = 75;
  localparam int unsigned AddrWidth = 3;

  // register word index (paddr[2])
  localparam logic RegPositionOffset = 1'b0;

  // request commands
  localparam logic CmdScan  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic [31:0] start_position;
    logic [31:0] url_length;
  } rsp_t;

  // head: first node of the sibling chain this node belongs to
  typedef struct packed {
    logic [NodeWidth-1:0] head;
    logic [NodeWidth-1:0] kid;
    logic [7:0]           ch;
  } trie_entry_t;

  typedef struct packed {
    logic                 hit;
    logic [NodeWidth-1:0] kid;
  } trie_hit_t;

  localparam trie_entry_t TrieTable [NodeCount] = '{
    '{7'd0,  7'd1,  8'h66}, '{7'd1,  7'd2,  8'h69}, '{7'd2,  7'd3,  8'h6c},
    '{7'd3,  7'd4,  8'h65}, '{7'd4,  7'd0,  8'h3a}, '{7'd1,  7'd6,  8'h74},
    '{7'd6,  7'd7,  8'h70}, '{7'd7,  7'd0,  8'h2e}, '{7'd7,  7'd0,  8'h3a},
    '{7'd7,  7'd10, 8'h73}, '{7'd10, 7'd0,  8'h3a}, '{7'd0,  7'd12, 8'h67},
    '{7'd12, 7'd13, 8'h6f}, '{7'd13, 7'd14, 8'h70}, '{7'd14, 7'd15, 8'h68},
    '{7'd15, 7'd16, 8'h65}, '{7'd16, 7'd17, 8'h72}, '{7'd17, 7'd0,  8'h3a},
    '{7'd0,  7'd19, 8'h68}, '{7'd19, 7'd20, 8'h74}, '{7'd20, 7'd21, 8'h74},
    '{7'd21, 7'd22, 8'h70}, '{7'd22, 7'd0,  8'h3a}, '{7'd22, 7'd24, 8'h73},
    '{7'd24, 7'd0,  8'h3a}, '{7'd0,  7'd26, 8'h6d}, '{7'd26, 7'd27, 8'h61},
    '{7'd27, 7'd28, 8'h69}, '{7'd28, 7'd29, 8'h6c}, '{7'd29, 7'd30, 8'h74},
    '{7'd30, 7'd31, 8'h6f}, '{7'd31, 7'd0,  8'h3a}, '{7'd26, 7'd33, 8'h6d},
    '{7'd33, 7'd34, 8'h73}, '{7'd34, 7'd0,  8'h3a}, '{7'd34, 7'd36, 8'h74},
    '{7'd36, 7'd0,  8'h3a}, '{7'd0,  7'd38, 8'h6e}, '{7'd38, 7'd39, 8'h65},
    '{7'd39, 7'd40, 8'h77}, '{7'd40, 7'd41, 8'h73}, '{7'd41, 7'd0,  8'h3a},
    '{7'd38, 7'd43, 8'h6e}, '{7'd43, 7'd44, 8'h74}, '{7'd44, 7'd45, 8'h70},
    '{7'd45, 7'd0,  8'h3a}, '{7'd0,  7'd47, 8'h70}, '{7'd47, 7'd48, 8'h72},
    '{7'd48, 7'd49, 8'h6f}, '{7'd49, 7'd50, 8'h73}, '{7'd50, 7'd51, 8'h70},
    '{7'd51, 7'd52, 8'h65}, '{7'd52, 7'd53, 8'h72}, '{7'd53, 7'd54, 8'h6f},
    '{7'd54, 7'd0,  8'h3a}, '{7'd0,  7'd56, 8'h72}, '{7'd56, 7'd57, 8'h74},
    '{7'd57, 7'd58, 8'h73}, '{7'd58, 7'd59, 8'h70}, '{7'd59, 7'd0,  8'h3a},
    '{7'd0,  7'd61, 8'h74}, '{7'd61, 7'd62, 8'h65}, '{7'd62, 7'd63, 8'h6c},
    '{7'd63, 7'd64, 8'h6e}, '{7'd64, 7'd65, 8'h65}, '{7'd65, 7'd66, 8'h74},
    '{7'd66, 7'd0,  8'h3a}, '{7'd0,  7'd68, 8'h77}, '{7'd68, 7'd69, 8'h61},
    '{7'd69, 7'd70, 8'h69}, '{7'd70, 7'd71, 8'h73}, '{7'd71, 7'd0,  8'h3a},
    '{7'd68, 7'd73, 8'h77}, '{7'd73, 7'd74, 8'h77}, '{7'd74, 7'd0,  8'h2e}
  };

  // upper case letters only
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

  // controls, space, dell, high half and the listed punctuation
  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    unique case (c) inside
      [8'h00:8'h20], [8'h7f:8'hff],
      8'h22, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h3c, 8'h3e,
      8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d: begin
        r = 1'b1;
      end
      default: begin
        r = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/ups_trie_match.sv
// ----------------------------------------------------------------------------
// ups_trie_match
// parallel compare of one folded character against a sibling chain of the trie
// ----------------------------------------------------------------------------
module ups_trie_match
  import ups_pkg::*;
(
  input  logic [NodeWidth-1:0] node_i,
  input  logic [7:0]           char_i,
  output trie_hit_t            match_o
);

  // chars inside one chain are distinct, so at most one node hits
  always_comb begin
    match_o = '0;
    for (int unsigned m = 0; m < NodeCount; m++) begin
      if (TrieTable[m].head == node_i && TrieTable[m].ch == char_i) begin
        match_o.hit = 1'b1;
        match_o.kid = match_o.kid | TrieTable[m].kid;
      end
    end
  end

endmodule

FILE: hw/rtl/ups_scan_core.sv
// ----------------------------------------------------------------------------
// ups_scan_core
// scanner state update for one request per cycle unless a held result stalls, and the result register
// ----------------------------------------------------------------------------
module ups_scan_core
  import ups_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  req_t                 item_i,
  input  logic [31:0]          position_offset_i,
  output logic                 item_take_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output rsp_t                 out_rsp_o
);

  typedef enum logic [2:0] {
    ModeInit      = 3'd0,
    ModeSep       = 3'd1,
    ModeSkip      = 3'd2,
    ModeHeader    = 3'd3,
    ModeBodyBegin = 3'd4,
    ModeBody      = 3'd5
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [NodeWidth-1:0] node_q, node_d;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [PosWidth-1:0]  start_q, start_d;
  logic                 started_q, started_d;
  logic [LenWidth-1:0]  len_q, len_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 rsp_q, rsp_d;

  logic [7:0] fc;
  logic       sep;
  logic       emit;
  logic       restart;
  logic       advance;
  logic [LenWidth-1:0] len_inc;
  trie_hit_t  cur_hit, root_hit;

  assign fc  = fold_char(item_i.char_code);
  assign sep = is_sep(item_i.char_code);

  ups_trie_match u_match_cur (
    .node_i  (node_q),
    .char_i  (fc),
    .match_o (cur_hit)
  );

  // a root hit is exactly a leading letter
  ups_trie_match u_match_root (
    .node_i  ('0),
    .char_i  (fc),
    .match_o (root_hit)
  );

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign len_inc     = (len_q == '1) ? len_q : len_q + 1'b1;

  always_comb begin
    mode_d    = mode_q;
    node_d    = node_q;
    pos_d     = pos_q;
    start_d   = start_q;
    started_d = started_q;
    len_d     = len_q;
    emit      = 1'b0;
    restart   = 1'b0;
    advance   = 1'b0;

    if (item_take_o) begin
      if (item_i.command == CmdFlush) begin
        emit = (mode_q == ModeBody);
      end else begin
        pos_d = pos_q + 1'b1;
        unique case (mode_q)
          ModeInit: begin
            if (root_hit.hit) begin
              restart = 1'b1;
            end else begin
              mode_d = sep ? ModeSep : ModeInit;
            end
          end
          ModeSep: begin
            if (!sep) begin
              if (root_hit.hit) begin
                restart = 1'b1;
              end else begin
                mode_d = ModeSkip;
              end
            end
          end
          ModeSkip: begin
            if (sep) begin
              mode_d = ModeSep;
            end
          end
          ModeHeader: begin
            if (cur_hit.hit) begin
              advance = 1'b1;
            end else if (root_hit.hit) begin
              restart = 1'b1;
            end else begin
              mode_d = ModeInit;
            end
          end
          ModeBodyBegin: begin
            if (sep) begin
              mode_d = ModeSep;
            end else begin
              len_d  = len_inc;
              mode_d = ModeBody;
            end
          end
          ModeBody: begin
            if (sep) begin
              mode_d = ModeSep;
              emit   = 1'b1;
            end else begin
              len_d = len_inc;
            end
          end
          default: begin
            mode_d = ModeInit;
          end
        endcase

        // new prefix on a leading letter, root nodes are never leaves
        if (restart) begin
          start_d   = pos_q;
          started_d = 1'b1;
          len_d     = LenWidth'(1);
          node_d    = root_hit.kid;
          mode_d    = ModeHeader;
        end

        if (advance) begin
          if (!started_q) begin
            start_d   = pos_q;
            started_d = 1'b1;
          end
          len_d = len_inc;
          if (cur_hit.kid == '0) begin
            mode_d = ModeBodyBegin;
          end else begin
            node_d = cur_hit.kid;
          end
        end
      end
    end

    out_valid_d = item_take_o ? emit : (out_valid_q && !out_ready_i);
    rsp_d       = rsp_q;
    if (emit) begin
      rsp_d.start_position = 32'(start_q) + position_offset_i;
      rsp_d.url_length     = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeInit;
      node_q      <= '0;
      pos_q       <= '0;
      start_q     <= '0;
      started_q   <= 1'b0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      mode_q      <= mode_d;
      node_q      <= node_d;
      pos_q       <= pos_d;
      start_q     <= start_d;
      started_q   <= started_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> rsp_q.url_length != '0)
    else $error("result with zero length");

  a_header_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeHeader || mode_q == ModeBodyBegin || mode_q == ModeBody) |-> started_q)
    else $error("prefix in progress without a start position");

  a_rose_from_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(mode_q == ModeBody))
    else $error("result raised outside the body");

  a_body_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeBodyBegin || mode_q == ModeBody) |-> len_q != '0)
    else $error("body reached with empty length");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && item_i.command == CmdScan) |=> pos_q == $past(pos_q) + 1'b1)
    else $error("position did not advance on a scanned byte");

endmodule

FILE: hw/rtl/url_prefix_scanner_top.sv
// ----------------------------------------------------------------------------
// url_prefix_scanner_top
// url scanner over a byte stream, one request per cycle unless a held result stalls, apb offset register
// ----------------------------------------------------------------------------
// path: an accepted request waits in the input register and is scanned from there;
//   a result it causes is written to the core's result register at that same scan
// throughput: one request per cycle unless a held result stalls, set by the trie
//   compare and state update in the scan core
// reset: asynchronous, all control state and the offset register clear at
//   once; no clearing pass, requests are taken right after reset
module url_prefix_scanner_top
  import ups_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  // apb configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // input register: holds one request while the core waits on the output
  logic  in_valid_q, in_valid_d;
  req_t  in_req_q, in_req_d;
  logic  core_take;

  // configuration
  logic [31:0] offset_q, offset_d;
  logic        cfg_write;

  // a request moves in whenever the held one is empty or leaves this cycle
  assign in_ready_o = !in_valid_q || core_take;

  always_comb begin
    in_valid_d = in_valid_q;
    in_req_d   = in_req_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        in_req_d = in_req_i;
      end
    end
  end

  // write lands in the access phase; only word index zero exists
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    offset_d = offset_q;
    if (cfg_write && paddr[2] == RegPositionOffset) begin
      offset_d = pwdata;
    end
  end

  assign prdata = (paddr[2] == RegPositionOffset) ? offset_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      offset_q   <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      offset_q   <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_req_q <= in_req_d;
  end

  // trie walk, mode state machine, position and length counters, result reg
  ups_scan_core u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_valid_i      (in_valid_q),
    .item_i            (in_req_q),
    .position_offset_i (offset_q),
    .item_take_o       (core_take),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .out_rsp_o         (out_rsp_o)
  );

endmodule

FILE: tb/url_prefix_scanner_checker.sv
// ----------------------------------------------------------------------------
// url_prefix_scanner_checker
// watches the request, result and apb channels of the url prefix scanner,
// tracks the scan state on its own and compares every result in order
// ----------------------------------------------------------------------------
module url_prefix_scanner_checker
  import ups_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  req_t                 in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  rsp_t                 out_rsp_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [AddrWidth-1:0] paddr_i,
  input  logic [31:0]          pwdata_i,
  input  logic [31:0]          prdata_i,
  input  logic                 pready_i,
  output int                   error_count_o,
  output int                   pending_o
);

  typedef enum logic [2:0] {
    ModeInit,
    ModeSep,
    ModeSkip,
    ModeHeader,
    ModeBodyBegin,
    ModeBody
  } scan_mode_e;

  // sibling / child links, zero means none
  typedef struct packed {
    logic [NodeWidth-1:0] sib;
    logic [NodeWidth-1:0] kid;
    logic [7:0]           chr;
  } link_t;

  localparam link_t Links [NodeCount] = '{
    '{7'd11, 7'd1,  "f"}, '{7'd5,  7'd2,  "i"}, '{7'd0,  7'd3,  "l"},
    '{7'd0,  7'd4,  "e"}, '{7'd0,  7'd0,  ":"}, '{7'd0,  7'd6,  "t"},
    '{7'd0,  7'd7,  "p"}, '{7'd8,  7'd0,  "."}, '{7'd9,  7'd0,  ":"},
    '{7'd0,  7'd10, "s"}, '{7'd0,  7'd0,  ":"}, '{7'd18, 7'd12, "g"},
    '{7'd0,  7'd13, "o"}, '{7'd0,  7'd14, "p"}, '{7'd0,  7'd15, "h"},
    '{7'd0,  7'd16, "e"}, '{7'd0,  7'd17, "r"}, '{7'd0,  7'd0,  ":"},
    '{7'd25, 7'd19, "h"}, '{7'd0,  7'd20, "t"}, '{7'd0,  7'd21, "t"},
    '{7'd0,  7'd22, "p"}, '{7'd23, 7'd0,  ":"}, '{7'd0,  7'd24, "s"},
    '{7'd0,  7'd0,  ":"}, '{7'd37, 7'd26, "m"}, '{7'd32, 7'd27, "a"},
    '{7'd0,  7'd28, "i"}, '{7'd0,  7'd29, "l"}, '{7'd0,  7'd30, "t"},
    '{7'd0,  7'd31, "o"}, '{7'd0,  7'd0,  ":"}, '{7'd0,  7'd33, "m"},
    '{7'd0,  7'd34, "s"}, '{7'd35, 7'd0,  ":"}, '{7'd0,  7'd36, "t"},
    '{7'd0,  7'd0,  ":"}, '{7'd46, 7'd38, "n"}, '{7'd42, 7'd39, "e"},
    '{7'd0,  7'd40, "w"}, '{7'd0,  7'd41, "s"}, '{7'd0,  7'd0,  ":"},
    '{7'd0,  7'd43, "n"}, '{7'd0,  7'd44, "t"}, '{7'd0,  7'd45, "p"},
    '{7'd0,  7'd0,  ":"}, '{7'd55, 7'd47, "p"}, '{7'd0,  7'd48, "r"},
    '{7'd0,  7'd49, "o"}, '{7'd0,  7'd50, "s"}, '{7'd0,  7'd51, "p"},
    '{7'd0,  7'd52, "e"}, '{7'd0,  7'd53, "r"}, '{7'd0,  7'd54, "o"},
    '{7'd0,  7'd0,  ":"}, '{7'd60, 7'd56, "r"}, '{7'd0,  7'd57, "t"},
    '{7'd0,  7'd58, "s"}, '{7'd0,  7'd59, "p"}, '{7'd0,  7'd0,  ":"},
    '{7'd67, 7'd61, "t"}, '{7'd0,  7'd62, "e"}, '{7'd0,  7'd63, "l"},
    '{7'd0,  7'd64, "n"}, '{7'd0,  7'd65, "e"}, '{7'd0,  7'd66, "t"},
    '{7'd0,  7'd0,  ":"}, '{7'd0,  7'd68, "w"}, '{7'd72, 7'd69, "a"},
    '{7'd0,  7'd70, "i"}, '{7'd0,  7'd71, "s"}, '{7'd0,  7'd0,  ":"},
    '{7'd0,  7'd73, "w"}, '{7'd0,  7'd74, "w"}, '{7'd0,  7'd0,  "."}
  };

  scan_mode_e           mode;
  logic [NodeWidth-1:0] node;
  logic [PosWidth-1:0]  char_pos;
  logic [PosWidth-1:0]  url_first;
  logic                 started;
  logic [LenWidth-1:0]  url_len;
  logic [31:0]          offset;
  rsp_t                 url_q [$];
  rsp_t                 want;

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  task automatic flag(input string what);
    $display("%0t url check: %s", $time, what);
    error_count_o++;
  endtask

  function automatic logic [7:0] lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'h20 : c;
  endfunction

  function automatic logic sep_char(input logic [7:0] c);
    return c < 8'h21 || c >= 8'h7f ||
           c inside {8'h22, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h3c, 8'h3e, 8'h5b,
                     8'h5c, 8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d};
  endfunction

  function automatic logic leading_char(input logic [7:0] c);
    return lower(c) inside {"f", "g", "h", "m", "n", "p", "r", "t", "w"};
  endfunction

  // walk the sibling chain starting at from
  function automatic logic find_link(input logic [NodeWidth-1:0] from,
                                     input logic [7:0] c,
                                     output logic [NodeWidth-1:0] hit);
    logic [NodeWidth-1:0] n;
    n   = from;
    hit = '0;
    for (int g = 0; g < NodeCount; g++) begin
      if (Links[n].chr == c) begin
        hit = n;
        return 1'b1;
      end
      if (Links[n].sib == '0) return 1'b0;
      n = Links[n].sib;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t url_report();
    rsp_t r;
    r.start_position = 32'(url_first) + offset;
    r.url_length     = url_len;
    return r;
  endfunction

  task automatic bump_length();
    if (url_len != '1) url_len++;
  endtask

  task automatic open_prefix();
    node    = '0;
    started = 1'b0;
    url_len = '0;
    mode    = ModeHeader;
  endtask

  task automatic header_step(input logic [7:0] c, input logic [PosWidth-1:0] idx);
    logic [7:0]           lc;
    logic [NodeWidth-1:0] hit;
    lc = lower(c);
    if (!find_link(node, lc, hit)) begin
      // mismatch: restart on a leading letter, else drop back to init
      if (!leading_char(lc)) begin
        mode = ModeInit;
        return;
      end
      open_prefix();
      if (!find_link(node, lc, hit)) begin
        mode = ModeInit;
        return;
      end
    end
    if (!started) begin
      url_first = idx;
      started   = 1'b1;
    end
    bump_length();
    if (Links[hit].kid == '0) begin
      mode = ModeBodyBegin;
    end else begin
      node = Links[hit].kid;
    end
  endtask

  task automatic scan_request(input req_t r);
    logic [PosWidth-1:0] idx;
    if (r.command == CmdFlush) begin
      // flush reports an open body and keeps the state
      if (mode == ModeBody) url_q.push_back(url_report());
      return;
    end
    idx      = char_pos;
    char_pos = char_pos + 1'b1;
    case (mode)
      ModeInit, ModeSep: begin
        if (leading_char(r.char_code)) begin
          open_prefix();
          header_step(r.char_code, idx);
        end else if (sep_char(r.char_code)) begin
          mode = ModeSep;
        end else begin
          mode = (mode == ModeSep) ? ModeSkip : ModeInit;
        end
      end
      ModeSkip: begin
        if (sep_char(r.char_code)) mode = ModeSep;
      end
      ModeHeader: begin
        header_step(r.char_code, idx);
      end
      ModeBodyBegin: begin
        if (sep_char(r.char_code)) begin
          mode = ModeSep;
        end else begin
          bump_length();
          mode = ModeBody;
        end
      end
      ModeBody: begin
        if (sep_char(r.char_code)) begin
          mode = ModeSep;
          url_q.push_back(url_report());
        end else begin
          bump_length();
        end
      end
      default: begin
        mode = ModeInit;
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode      = ModeInit;
      node      = '0;
      char_pos  = '0;
      url_first = '0;
      started   = 1'b0;
      url_len   = '0;
      offset    = '0;
      url_q.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == RegPositionOffset) begin
        if (pwrite_i) begin
          offset = pwdata_i;
        end else if (prdata_i !== offset) begin
          flag($sformatf("offset read %h, want %h", prdata_i, offset));
        end
      end
      if (in_valid_i && in_ready_i) scan_request(in_req_i);
      if (out_valid_i && out_ready_i) begin
        if (url_q.size() == 0) begin
          flag($sformatf("unexpected url start %h len %0d",
                         out_rsp_i.start_position, out_rsp_i.url_length));
        end else begin
          want = url_q.pop_front();
          if (out_rsp_i.start_position !== want.start_position) begin
            flag($sformatf("start %h, want %h",
                           out_rsp_i.start_position, want.start_position));
          end
          if (out_rsp_i.url_length !== want.url_length) begin
            flag($sformatf("length %0d, want %0d",
                           out_rsp_i.url_length, want.url_length));
          end
        end
      end
      pending_o = url_q.size();
    end
  end

endmodule

FILE: tb/url_prefix_scanner_top_tb.sv
// ----------------------------------------------------------------------------
// url_prefix_scanner_top_tb
// drives byte and flush requests into the url scanner over several offset
// settings; a side checker predicts every url report and counts mismatches
// ----------------------------------------------------------------------------
module url_prefix_scanner_top_tb;
  import ups_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  req_t                 in_req_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  rsp_t                 out_rsp_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int                   error_count;
  int                   url_pending;
  // random stalls on both channels, cleared for one whole phase
  bit                   idle_en;
  int                   sent;
  logic [31:0]          phase_offset [4];

  // punctuation that ends a url
  localparam logic [7:0] Punct [15] = '{
    8'h22, 8'h27, 8'h28, 8'h29, 8'h2a, 8'h3c, 8'h3e, 8'h5b,
    8'h5c, 8'h5d, 8'h5e, 8'h60, 8'h7b, 8'h7c, 8'h7d
  };

  url_prefix_scanner_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  url_prefix_scanner_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_rsp_i     (out_rsp_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .pready_i      (pready),
    .error_count_o (error_count),
    .pending_o     (url_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: stall at random while idling is on
  always @(negedge clk_i) begin
    out_ready_i <= !idle_en || ($urandom_range(0, 99) >= 29);
  end

  function automatic string scheme_text(input int k);
    case (k)
      0:       return "file:";
      1:       return "ftp.";
      2:       return "ftp:";
      3:       return "ftps:";
      4:       return "gopher:";
      5:       return "http:";
      6:       return "https:";
      7:       return "mailto:";
      8:       return "mms:";
      9:       return "mmst:";
      10:      return "news:";
      11:      return "nntp:";
      12:      return "prospero:";
      13:      return "rtsp:";
      14:      return "telnet:";
      15:      return "wais:";
      default: return "www.";
    endcase
  endfunction

  // controls and space, the high half with del, or listed punctuation
  function automatic logic [7:0] pick_sep();
    int k;
    k = $urandom_range(0, 9);
    if (k < 3) return 8'($urandom_range(0, 32));
    if (k < 5) return 8'($urandom_range(127, 255));
    return Punct[$urandom_range(0, 14)];
  endfunction

  // bytes that keep a url body going
  function automatic logic [7:0] pick_body();
    string s;
    s = "abcfhmwxyz0189-_./:?=&%#~@!$+,;AMZ";
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) return c - 8'h20;
    return c;
  endfunction

  // one request; entered and left at a falling edge, valid stays up on
  // return so that a back-to-back request needs no second assignment
  task automatic send_req(input logic cmd, input logic [7:0] ch);
    while (idle_en && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    in_req_i.command   <= cmd;
    in_req_i.char_code <= ch;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_text(input string s, input bit mixed);
    for (int i = 0; i < s.len(); i++) begin
      send_req(CmdScan, mixed ? mix_case(s[i]) : s[i]);
    end
  endtask

  // apb setup then access phase, pready is tied high
  task automatic apb_xfer(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {RegPositionOffset, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // drop valid, drain all reports, then let the pipe clear
  task automatic settle();
    in_valid_i <= 1'b0;
    while (url_pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_snippet();
    int    kind;
    int    k;
    int    body;
    int    cut;
    string s;
    kind = $urandom_range(0, 99);
    s    = scheme_text($urandom_range(0, 16));
    if (kind < 70) begin
      // well formed: separator, scheme in mixed case, body, then a terminator, a flush run or nothing
      repeat ($urandom_range(1, 2)) send_req(CmdScan, pick_sep());
      send_text(s, 1'b1);
      k    = $urandom_range(0, 9);
      body = (k == 0) ? 0 : (k == 9) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (body) send_req(CmdScan, pick_body());
      k = $urandom_range(0, 99);
      if (k < 70) begin
        send_req(CmdScan, pick_sep());
      end else if (k < 85) begin
        // flush mid body, extend the same url, maybe flush it again
        send_req(CmdFlush, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) send_req(CmdScan, pick_body());
        if ($urandom_range(0, 1) == 1) send_req(CmdFlush, 8'($urandom_range(0, 255)));
        send_req(CmdScan, pick_sep());
      end
    end else if (kind < 85) begin
      // broken scheme followed by any byte
      send_req(CmdScan, pick_sep());
      cut = $urandom_range(1, s.len() - 1);
      send_text(s.substr(0, cut - 1), 1'b1);
      send_req(CmdScan, 8'($urandom_range(0, 255)));
    end else begin
      // raw noise with the odd flush
      repeat ($urandom_range(1, 6)) begin
        send_req(($urandom_range(0, 5) == 0) ? CmdFlush : CmdScan,
                 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    idle_en     = 1'b1;
    sent        = 0;
    phase_offset[0] = 32'hffff_ffff;
    phase_offset[1] = 32'h8000_0000;
    phase_offset[2] = $urandom;
    phase_offset[3] = 32'h0000_0000;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_xfer(1'b1, 32'h0000_0000);
    apb_xfer(1'b0, 32'h0000_0000);

    // directed: flush with nothing open gives no report
    send_req(CmdFlush, 8'hff);
    // mixed case scheme, flush inside the body, extend, flush, end on 0xff
    send_text("HTTPs:a", 1'b0);
    send_req(CmdFlush, 8'h00);
    send_req(CmdScan, "b");
    send_req(CmdFlush, 8'h5a);
    send_req(CmdScan, 8'hff);
    // separator right after the scheme drops it
    send_text("ftp:", 1'b0);
    send_req(CmdScan, 8'h7f);
    // mismatch on a leading letter restarts the scheme there
    send_text("hwww.z", 1'b0);
    send_req(CmdScan, 8'h00);
    // mismatch on a non-leading letter returns to init
    send_text("fq", 1'b0);

    // random phases, each under a new offset; the third one never stalls
    for (int p = 0; p < 4; p++) begin
      settle();
      apb_xfer(1'b1, phase_offset[p]);
      apb_xfer(1'b0, phase_offset[p]);
      idle_en = (p != 2);
      while (sent < 26 + 256 * (p + 1)) send_snippet();
    end

    settle();
    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
